// ===== rtl/skh_pkg.sv =====
// Shared types and constants for the SipHash-2-4 block.
// No dependencies; imported by skh_round, skh_core and the top level.
`default_nettype none
package skh_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned VbW    = 4;
  localparam int unsigned LenW   = 8;
  localparam int unsigned NBytes = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [WordW-1:0] SEED0 = 64'h736f6d6570736575;
  localparam logic [WordW-1:0] SEED1 = 64'h646f72616e646f6d;
  localparam logic [WordW-1:0] SEED2 = 64'h6c7967656e657261;
  localparam logic [WordW-1:0] SEED3 = 64'h7465646279746573;
  localparam logic [WordW-1:0] FIN_MARK = 64'h00000000000000ff;

  localparam logic [VbW-1:0] VB_FULL = 4'd8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_KEY_HIGH = 1'b1;

  typedef logic [3:0][WordW-1:0] skh_lanes_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [VbW-1:0]   vbytes;
    logic             last;
  } skh_item_t;

endpackage
`default_nettype wire

// ===== rtl/skh_round.sv =====
// One SipRound over the four 64-bit lanes, purely combinational.
// Depends on skh_pkg for the lane type.
`default_nettype none
module skh_round (
  input  wire skh_pkg::skh_lanes_t lanes_in,
  output skh_pkg::skh_lanes_t      lanes_out
);
  import skh_pkg::*;

  logic [WordW-1:0] a0, b0, c0, d0;
  logic [WordW-1:0] a1, b1, c1, d1;
  logic [WordW-1:0] a2, b2, c2, d2;

  always_comb begin
    // first half: two adds in parallel, rotate/xor the partners
    a0 = lanes_in[0] + lanes_in[1];
    b0 = {lanes_in[1][50:0], lanes_in[1][63:51]} ^ a0;
    a1 = {a0[31:0], a0[63:32]};
    c0 = lanes_in[2] + lanes_in[3];
    d0 = {lanes_in[3][47:0], lanes_in[3][63:48]} ^ c0;
    // second half: cross the pairs
    a2 = a1 + d0;
    d1 = {d0[42:0], d0[63:43]} ^ a2;
    c1 = c0 + b0;
    b1 = {b0[46:0], b0[63:47]} ^ c1;
    c2 = {c1[31:0], c1[63:32]};
    b2 = b1;
    d2 = d1;
    lanes_out[0] = a2;
    lanes_out[1] = b2;
    lanes_out[2] = c2;
    lanes_out[3] = d2;
  end

endmodule
`default_nettype wire

// ===== rtl/skh_core.sv =====
// Lane state and round sequencer: seeds, absorbs blocks and finalizes
// through one shared SipRound unit. Depends on skh_pkg and skh_round.
`default_nettype none
module skh_core (
  input  wire                     clk,
  input  wire                     rst,
  input  wire [skh_pkg::WordW-1:0] key_low,
  input  wire [skh_pkg::WordW-1:0] key_high,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire skh_pkg::skh_item_t item,
  input  wire                     out_free,
  output logic                    done,
  output logic [skh_pkg::WordW-1:0] hash
);
  import skh_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_COMP = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state, state_next;
  logic [1:0]       cnt, cnt_next;
  logic             open, open_next;
  logic             extra, extra_next;
  logic             last_flag, last_flag_next;
  logic [LenW-1:0]  len, len_next;
  logic [WordW-1:0] blk, blk_next;
  skh_lanes_t       v, v_next, base, rnd;

  logic [VbW-1:0]   vb_sat;
  logic             full_word;
  logic [LenW-1:0]  len_add, len_acc;
  logic [WordW-1:0] masked;
  logic [WordW-1:0] first_blk;

  skh_round u_round (
    .lanes_in  (v),
    .lanes_out (rnd)
  );

  always_comb begin
    vb_sat    = (item.vbytes > VB_FULL) ? VB_FULL : item.vbytes;
    full_word = !item.last || (vb_sat == VB_FULL);
    len_add   = full_word ? LenW'(NBytes) : LenW'(vb_sat);
    len_acc   = (open ? len : '0) + len_add;
    for (int i = 0; i < NBytes; i++) begin
      masked[8*i +: 8] = (VbW'(i) < vb_sat) ? item.word[8*i +: 8] : 8'h00;
    end
    // short last word: leftover bytes plus length in the top byte
    first_blk = full_word ? item.word : (masked | {len_acc, 56'b0});
    if (open) begin
      base = v;
    end else begin
      base[0] = key_low ^ SEED0;
      base[1] = key_high ^ SEED1;
      base[2] = key_low ^ SEED2;
      base[3] = key_high ^ SEED3;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    open_next      = open;
    extra_next     = extra;
    last_flag_next = last_flag;
    len_next       = len;
    blk_next       = blk;
    v_next         = v;
    done           = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          v_next         = base;
          v_next[3]      = base[3] ^ first_blk;
          blk_next       = first_blk;
          len_next       = len_acc;
          open_next      = 1'b1;
          last_flag_next = item.last;
          extra_next     = item.last && full_word;
          cnt_next       = 2'd0;
          state_next     = S_COMP;
        end
      end
      S_COMP: begin
        v_next   = rnd;
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd1) begin
          v_next[0] = rnd[0] ^ blk;
          cnt_next  = 2'd0;
          if (extra) begin
            // full last word absorbed; queue the length-only block
            blk_next   = {len, 56'b0};
            v_next[3]  = rnd[3] ^ {len, 56'b0};
            extra_next = 1'b0;
          end else if (last_flag) begin
            v_next[2]  = rnd[2] ^ FIN_MARK;
            state_next = S_FIN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_FIN: begin
        v_next   = rnd;
        cnt_next = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register can take the hash
        if (out_free) begin
          done       = 1'b1;
          open_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= 2'd0;
      open      <= 1'b0;
      extra     <= 1'b0;
      last_flag <= 1'b0;
      len       <= '0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      open      <= open_next;
      extra     <= extra_next;
      last_flag <= last_flag_next;
      len       <= len_next;
    end
    v   <= v_next;
    blk <= blk_next;
  end

  assign in_ready = (state == S_IDLE);
  assign hash     = v[0] ^ v[1] ^ v[2] ^ v[3];

endmodule
`default_nettype wire

// ===== rtl/keyed_sip_hash_2_4.sv =====
// Sequencing: a non-last word holds the block for its transfer cycle plus two
// SipRounds on the shared round unit. A last word runs 6 rounds (8 if it holds
// 8 bytes) before m_tvalid rises. While a message streams, no new word is taken
// until the two rounds of the one before are done; after a last word, s_tready
// returns in the same cycle that m_tvalid rises, later if m_tready stalls.
// Reset: rst is synchronous, active high; clears keys, sequencer and output valid.
`default_nettype none
module keyed_sip_hash_2_4 (
  input  wire         clk,
  input  wire         rst,
  // configuration write port
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [63:0] cfg_data,
  // input stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [71:0] s_tdata,   // [63:0] message_word, [67:64] valid_bytes, [71:68] zero
  input  wire         s_tlast,   // last_word
  // output stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata    // [63:0] hash_value
);
  import skh_pkg::*;

  logic [WordW-1:0] key_low, key_high;
  skh_item_t        item;
  logic             core_ready, done, out_free;
  logic [WordW-1:0] hash;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.word   = s_tdata[63:0];
  assign item.vbytes = s_tdata[67:64];
  assign item.last   = s_tlast;

  assign out_free = !m_tvalid || m_tready;

  skh_core u_core (
    .clk      (clk),
    .rst      (rst),
    .key_low  (key_low),
    .key_high (key_high),
    .in_valid (s_tvalid),
    .in_ready (core_ready),
    .item     (item),
    .out_free (out_free),
    .done     (done),
    .hash     (hash)
  );

  assign s_tready = core_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (done) begin
      m_tdata <= hash;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/skh_checker.sv =====
// Port-level checks for keyed_sip_hash_2_4, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module skh_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [63:0] m_tdata
);

  // a stalled hash holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("hash changed or dropped while stalled");

  // every word spends two rounds before the next transfer
  a_two_rounds: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input accepted before two rounds finished");

  // a non-last word yields no hash while its rounds run
  a_no_hash_mid: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tlast && !m_tvalid |=> !m_tvalid ##1 !m_tvalid)
    else $error("hash produced for a non-last word");

  // a last word's hash does not appear early, while its first rounds run
  a_fin_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast && !m_tvalid |=> !m_tvalid ##1 !m_tvalid ##1 !m_tvalid)
    else $error("hash appeared too early after last word");

endmodule

bind keyed_sip_hash_2_4 skh_checker u_skh_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== verif/keyed_sip_hash_2_4_tb.sv =====
// Self-checking testbench for keyed_sip_hash_2_4 (SipHash-2-4 over 64-bit words).
// Needs skh_pkg and the RTL top; predicts every hash locally and compares each
// transfer on the output stream against the oldest predicted value.
`timescale 1ns / 100ps
module keyed_sip_hash_2_4_tb;
  import skh_pkg::*;

  typedef logic [63:0] u64;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 20;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  keyed_sip_hash_2_4 dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // pending words and predicted hashes
  skh_item_t word_q[$];
  u64        hash_q[$];

  // predictor state
  u64         key_lo, key_hi;
  u64         lanes[4];
  logic [7:0] len_byte;
  logic       msg_open;

  int unsigned cycles = 0;
  int unsigned fails = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  bit          quiet = 1'b0;
  bit          in_xfer = 1'b0;
  bit          have_hash;
  u64          new_hash, want;
  skh_item_t   nxt;

  function automatic u64 rotl(input u64 v, input int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  function automatic void mix_round();
    u64 a, b, c, d;
    a = lanes[0]; b = lanes[1]; c = lanes[2]; d = lanes[3];
    a += b; b = rotl(b, 13); b ^= a; a = rotl(a, 32);
    c += d; d = rotl(d, 16); d ^= c;
    a += d; d = rotl(d, 21); d ^= a;
    c += b; b = rotl(b, 17); b ^= c; c = rotl(c, 32);
    lanes[0] = a; lanes[1] = b; lanes[2] = c; lanes[3] = d;
  endfunction

  function automatic void mix_block(input u64 blk);
    lanes[3] ^= blk;
    mix_round();
    mix_round();
    lanes[0] ^= blk;
  endfunction

  // Advance the hash state by one word; returns 1 with the hash on a last word.
  function automatic bit predict_hash(input u64 w, input logic [3:0] vb, input logic lst,
                                      output u64 h);
    u64          fin;
    int unsigned nb;
    h = '0;
    if (!msg_open) begin
      lanes[0] = key_lo ^ SEED0;
      lanes[1] = key_hi ^ SEED1;
      lanes[2] = key_lo ^ SEED2;
      lanes[3] = key_hi ^ SEED3;
      len_byte = '0;
      msg_open = 1'b1;
    end
    if (!lst) begin
      mix_block(w);
      len_byte = len_byte + 8'd8;
      return 1'b0;
    end
    nb = (vb > VB_FULL) ? 8 : vb;
    if (nb == 8) begin
      mix_block(w);
      len_byte = len_byte + 8'd8;
      fin = '0;
    end else begin
      fin = w & ((64'd1 << (8 * nb)) - 64'd1);
      len_byte = len_byte + 8'(nb);
    end
    fin |= {len_byte, 56'd0};
    mix_block(fin);
    lanes[2] ^= FIN_MARK;
    repeat (4) mix_round();
    h = lanes[0] ^ lanes[1] ^ lanes[2] ^ lanes[3];
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  // monitor: config writes, accepted words and hash transfers
  always @(posedge clk) begin
    if (rst) begin
      key_lo = '0; key_hi = '0;
      lanes[0] = '0; lanes[1] = '0; lanes[2] = '0; lanes[3] = '0;
      len_byte = '0;
      msg_open = 1'b0;
      in_xfer = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_LOW:  key_lo = cfg_data;
          REG_KEY_HIGH: key_hi = cfg_data;
          default: ;
        endcase
      end
      // check the output first so a hash predicted this edge is not matched early
      if (m_tvalid && m_tready) begin
        if (hash_q.size() == 0) begin
          $display("%0t: unexpected hash, expected none, got %h", $time, m_tdata);
          fails++;
        end else begin
          want = hash_q.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: hash mismatch, expected %h, got %h", $time, want, m_tdata);
            fails++;
          end
        end
      end
      in_xfer = s_tvalid && s_tready;
      if (in_xfer) begin
        have_hash = predict_hash(s_tdata[63:0], s_tdata[67:64], s_tlast, new_hash);
        if (have_hash) hash_q.push_back(new_hash);
      end
    end
  end

  // driver: present the next word once the previous transfer is done
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_xfer) begin
      if (src_gap > 0 || word_q.size() == 0) begin
        if (src_gap > 0) src_gap--;
        s_tvalid <= 1'b0;
      end else begin
        nxt = word_q.pop_front();
        s_tdata <= {4'd0, nxt.vbytes, nxt.word};
        s_tlast <= nxt.last;
        s_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 9);
      end
    end
  end

  // sink: random stall bursts on m_tready
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 6) == 0) snk_gap = $urandom_range(1, 9);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic u64 rand_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void put_word(input u64 w, input logic [3:0] vb, input logic lst);
    skh_item_t it;
    it.word = w;
    it.vbytes = vb;
    it.last = lst;
    word_q.push_back(it);
  endfunction

  // queue one message of random content; valid_bytes is noise on non-last words
  function automatic int put_message(input int nwords);
    logic [3:0] vb;
    for (int i = 1; i < nwords; i++) put_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
    vb = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    put_word(rand_word(), vb, 1'b1);
    return nwords;
  endfunction

  // wait until every word is taken and every hash is back, then let the block settle
  task automatic drain();
    while (word_q.size() != 0 || s_tvalid) @(posedge clk);
    while (hash_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_key(input logic [0:0] idx, input u64 val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int n;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // key still at its reset value of zero
    put_word('0, 4'd0, 1'b1);                  // empty message
    put_word('1, 4'd8, 1'b1);                  // one full last word
    put_word(rand_word(), 4'd15, 1'b1);        // oversized count saturates to a full word
    put_word('1, 4'd0, 1'b0);
    put_word('0, 4'd8, 1'b1);
    drain();

    write_key(REG_KEY_LOW, '1);
    write_key(REG_KEY_HIGH, '1);
    put_word('1, 4'd3, 1'b1);                  // bytes above the count must be dropped
    put_word(rand_word(), 4'd5, 1'b0);
    put_word(rand_word(), 4'd7, 1'b1);
    put_word(rand_word(), 4'd1, 1'b1);
    put_word(rand_word(), 4'd9, 1'b1);
    put_word(rand_word(), 4'd2, 1'b0);
    put_word(rand_word(), 4'd0, 1'b1);
    // leave a message open across a key change; the old key must stay in force
    put_word(rand_word(), 4'd10, 1'b0);
    drain();
    write_key(REG_KEY_LOW, {$urandom, $urandom});
    put_word(rand_word(), 4'd12, 1'b0);
    put_word(rand_word(), 4'd6, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_key(REG_KEY_LOW, '0);
          write_key(REG_KEY_HIGH, '1);
        end
        1: begin
          write_key(REG_KEY_LOW, '1);
          write_key(REG_KEY_HIGH, '0);
        end
        default: begin
          write_key(REG_KEY_LOW, {$urandom, $urandom});
          write_key(REG_KEY_HIGH, {$urandom, $urandom});
        end
      endcase
      quiet = (ph == 5);
      n = 0;
      // one message past 256 bytes so the length byte wraps
      if (ph == 0) n += put_message($urandom_range(33, 40));
      while (n < 135) begin
        n += put_message(($urandom_range(0, 24) == 0) ? $urandom_range(7, 40)
                                                       : $urandom_range(1, 6));
      end
      drain();
    end

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/skh_pkg.sv
rtl/skh_round.sv
rtl/skh_core.sv
rtl/keyed_sip_hash_2_4.sv
rtl/skh_checker.sv
verif/keyed_sip_hash_2_4_tb.sv
